@@ rtl/fsfs_pkg.sv @@
// Shared types and constants for the frame score fuse and smoothing block.
// Used by the top level and by the serial divider. Depends on nothing else.
package fsfs_pkg;

    typedef logic [15:0] q15_t;

    // Fixed-point constants
    localparam q15_t ONE_Q15       = 16'd32768;
    localparam q15_t ONE_Q12       = 16'd4096;
    localparam q15_t MOTION_THRESH = 16'd16384;
    localparam q15_t TEXT_THRESH   = 16'd3276;
    localparam logic [32:0] ROUND15 = 33'd16384;
    localparam logic [32:0] ROUND12 = 33'd2048;

    // Configuration register indexes
    localparam logic [2:0] CFG_WEIGHT_SCENE  = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_MOTION = 3'd1;
    localparam logic [2:0] CFG_WEIGHT_TEXT   = 3'd2;
    localparam logic [2:0] CFG_SCENE_BOOST   = 3'd3;
    localparam logic [2:0] CFG_MOTION_BOOST  = 3'd4;
    localparam logic [2:0] CFG_TEXT_BOOST    = 3'd5;
    localparam logic [2:0] CFG_EMA_ALPHA     = 3'd6;
    localparam logic [2:0] CFG_SMOOTH_WINDOW = 3'd7;

    // Boost slot numbers, applied in this order
    localparam logic [1:0] BOOST_SCENE  = 2'd0;
    localparam logic [1:0] BOOST_MOTION = 2'd1;
    localparam logic [1:0] BOOST_TEXT   = 2'd2;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/frame_score_fuse_smooth.sv @@
// Throughput: a new frame is accepted only once the previous result is loaded into the output
// register; a single 16x16 multiplier steps through the three weights, three boosts and two
// EMA terms, the divider one bit a cycle.
// Reset: asynchronous active low; config registers take their defaults, history cleared,
// ring contents undefined until written.
module frame_score_fuse_smooth
    import fsfs_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] scene_score,
    input  logic [15:0] motion_score,
    input  logic [15:0] text_score,
    input  logic        scene_change,
    input  logic [15:0] motion_level,
    input  logic [15:0] text_change_ratio,
    input  logic [30:0] frame_number,
    input  logic [62:0] time_stamp,
    input  logic        restart,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] final_score,
    output logic [15:0] scene_part,
    output logic [15:0] motion_part,
    output logic [15:0] text_part,
    output logic [30:0] frame_number_out,
    output logic [62:0] time_stamp_out
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int OW = PW + 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = $clog2(WINDOW_MAX * 32768 + 1);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_PS   = 14'b00000000000010,
        ST_PM   = 14'b00000000000100,
        ST_PT   = 14'b00000000001000,
        ST_FUSE = 14'b00000000010000,
        ST_BMUL = 14'b00000000100000,
        ST_BAPP = 14'b00000001000000,
        ST_SEL  = 14'b00000010000000,
        ST_EM1  = 14'b00000100000000,
        ST_EM2  = 14'b00001000000000,
        ST_EM3  = 14'b00010000000000,
        ST_UPD  = 14'b00100000000000,
        ST_DIV  = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    q15_t       w_scene_reg, w_motion_reg, w_text_reg;
    q15_t       b_scene_reg, b_motion_reg, b_text_reg;
    q15_t       alpha_reg;
    logic [5:0] window_reg;

    // latched item
    q15_t        s_reg, m_reg, t_reg, ml_reg, tr_reg;
    logic        sc_reg;
    logic [30:0] fn_reg;
    logic [62:0] ts_reg;

    // history
    logic          seen_reg, seen_next;
    q15_t          ema_reg, ema_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg, sum_next;

    // working registers
    logic [31:0] prod_reg;
    logic [31:0] acc_reg, acc_next;
    logic [16:0] ps_reg, ps_next, pm_reg, pm_next, pt_reg, pt_next;
    q15_t        v_reg, v_next;
    q15_t        res_reg, res_next;
    logic [1:0]  bidx_reg, bidx_next;
    logic        drop_reg, drop_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    q15_t        o_final_reg, o_sp_reg, o_mp_reg, o_tp_reg;
    logic [30:0] o_fn_reg;
    logic [62:0] o_ts_reg;
    logic        out_load;

    logic        accept;
    q15_t        mul_a, mul_b;
    logic [32:0] r15, r12, esum;
    logic [16:0] part_val;
    logic [20:0] boost_raw;
    q15_t        boost_val;
    logic [18:0] fsum;
    q15_t        fused;
    q15_t        factor;
    logic        trig;
    logic        ema_ok;
    logic        win_over;
    logic [CW-1:0] win;
    logic [OW-1:0] old_tmp;
    logic [PW-1:0] oldest;
    q15_t          ring_rdata;
    logic          ring_we;
    logic          div_start;
    logic [SW-1:0] div_quo;
    div_stat_t     div_stat;

    function automatic q15_t clamp17(input logic [16:0] x);
        clamp17 = (x > 17'(ONE_Q15)) ? ONE_Q15 : x[15:0];
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_scene_reg  <= 16'd14746;
            w_motion_reg <= 16'd6554;
            w_text_reg   <= 16'd11469;
            b_scene_reg  <= ONE_Q12;
            b_motion_reg <= ONE_Q12;
            b_text_reg   <= ONE_Q12;
            alpha_reg    <= '0;
            window_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WEIGHT_SCENE:  w_scene_reg  <= cfg_data;
                CFG_WEIGHT_MOTION: w_motion_reg <= cfg_data;
                CFG_WEIGHT_TEXT:   w_text_reg   <= cfg_data;
                CFG_SCENE_BOOST:   b_scene_reg  <= cfg_data;
                CFG_MOTION_BOOST:  b_motion_reg <= cfg_data;
                CFG_TEXT_BOOST:    b_text_reg   <= cfg_data;
                CFG_EMA_ALPHA:     alpha_reg    <= cfg_data;
                CFG_SMOOTH_WINDOW: window_reg   <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // Select shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PS:
            begin
                mul_a = s_reg;
                mul_b = w_scene_reg;
            end
            ST_PM:
            begin
                mul_a = m_reg;
                mul_b = w_motion_reg;
            end
            ST_PT:
            begin
                mul_a = t_reg;
                mul_b = w_text_reg;
            end
            ST_BMUL:
            begin
                mul_a = v_reg;
                mul_b = factor;
            end
            ST_EM1:
            begin
                mul_a = alpha_reg;
                mul_b = v_reg;
            end
            ST_EM2:
            begin
                mul_a = ONE_Q15 - alpha_reg;
                mul_b = ema_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Boost factor and trigger of the current slot
    always_comb
    begin
        case (bidx_reg)
            BOOST_SCENE:
            begin
                factor = b_scene_reg;
                trig   = sc_reg;
            end
            BOOST_MOTION:
            begin
                factor = b_motion_reg;
                trig   = ml_reg > MOTION_THRESH;
            end
            BOOST_TEXT:
            begin
                factor = b_text_reg;
                trig   = tr_reg > TEXT_THRESH;
            end
            default:
            begin
                factor = ONE_Q12;
                trig   = 1'b0;
            end
        endcase
    end

    // Rounding and clamping of the registered product
    assign r15       = {1'b0, prod_reg} + ROUND15;
    assign part_val  = r15[31:15];
    assign r12       = {1'b0, prod_reg} + ROUND12;
    assign boost_raw = r12[32:12];
    assign boost_val = (boost_raw > 21'(ONE_Q15)) ? ONE_Q15 : boost_raw[15:0];
    assign esum      = {1'b0, acc_reg} + {1'b0, prod_reg} + ROUND15;
    assign fsum      = {2'b00, ps_reg} + {2'b00, pm_reg} + {2'b00, part_val};
    assign fused     = (fsum > 19'(ONE_Q15)) ? ONE_Q15 : fsum[15:0];

    // Smoothing mode and ring addressing
    assign ema_ok   = (alpha_reg != '0) && (alpha_reg <= ONE_Q15);
    assign win_over = 32'(window_reg) > 32'(WINDOW_MAX);
    assign win      = win_over ? CW'(WINDOW_MAX) : CW'(window_reg);
    assign old_tmp  = OW'(ptr_reg) + OW'(WINDOW_MAX) - OW'(count_reg);
    assign oldest   = (old_tmp >= OW'(WINDOW_MAX)) ? PW'(old_tmp - OW'(WINDOW_MAX))
                                                  : old_tmp[PW-1:0];
    assign ring_we   = (state_reg == ST_UPD);
    assign div_start = (state_reg == ST_UPD);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        ema_next       = ema_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        ps_next        = ps_reg;
        pm_next        = pm_reg;
        pt_next        = pt_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        bidx_next      = bidx_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        seen_next  = 1'b0;
                        ema_next   = '0;
                        ptr_next   = '0;
                        count_next = '0;
                        sum_next   = '0;
                    end
                    state_next = ST_PS;
                end
            end
            ST_PS:
            begin
                state_next = ST_PM;
            end
            ST_PM:
            begin
                ps_next    = part_val;
                state_next = ST_PT;
            end
            ST_PT:
            begin
                pm_next    = part_val;
                state_next = ST_FUSE;
            end
            ST_FUSE:
            begin
                pt_next    = part_val;
                v_next     = fused;
                bidx_next  = BOOST_SCENE;
                state_next = ST_BMUL;
            end
            ST_BMUL:
            begin
                state_next = ST_BAPP;
            end
            ST_BAPP:
            begin
                if ((factor > ONE_Q12) && trig)
                begin
                    v_next = boost_val;
                end
                if (bidx_reg == BOOST_TEXT)
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    bidx_next  = bidx_reg + 2'd1;
                    state_next = ST_BMUL;
                end
            end
            ST_SEL:
            begin
                if (ema_ok)
                begin
                    if (!seen_reg && (count_reg == '0))
                    begin
                        ema_next   = v_reg;
                        seen_next  = 1'b1;
                        res_next   = v_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_EM1;
                    end
                end
                else if (win <= CW'(1))
                begin
                    res_next   = v_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    drop_next  = count_reg >= win;
                    state_next = ST_UPD;
                end
            end
            ST_EM1:
            begin
                state_next = ST_EM2;
            end
            ST_EM2:
            begin
                acc_next   = prod_reg;
                state_next = ST_EM3;
            end
            ST_EM3:
            begin
                ema_next   = esum[30:15];
                seen_next  = 1'b1;
                res_next   = esum[30:15];
                state_next = ST_OUT;
            end
            ST_UPD:
            begin
                // drop the oldest value when the window is full, then add the new one
                sum_next   = sum_reg - (drop_reg ? SW'(ring_rdata) : SW'(0)) + SW'(v_reg);
                count_next = count_reg - CW'(drop_reg) + CW'(1);
                ptr_next   = (ptr_reg == PW'(WINDOW_MAX - 1)) ? '0 : ptr_reg + PW'(1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = div_quo[15:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= 1'b0;
            ema_reg       <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            bidx_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            ema_reg       <= ema_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            bidx_reg      <= bidx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers: hold the beat, run the multiplier, load the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg  <= scene_score;
            m_reg  <= motion_score;
            t_reg  <= text_score;
            sc_reg <= scene_change;
            ml_reg <= motion_level;
            tr_reg <= text_change_ratio;
            fn_reg <= frame_number;
            ts_reg <= time_stamp;
        end
        prod_reg <= 32'(mul_a) * 32'(mul_b);
        acc_reg  <= acc_next;
        ps_reg   <= ps_next;
        pm_reg   <= pm_next;
        pt_reg   <= pt_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            o_final_reg <= res_reg;
            o_sp_reg    <= clamp17(ps_reg);
            o_mp_reg    <= clamp17(pm_reg);
            o_tp_reg    <= clamp17(pt_reg);
            o_fn_reg    <= fn_reg;
            o_ts_reg    <= ts_reg;
        end
    end

    // History ring
    fsfs_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ptr_reg),
        .wdata (v_reg),
        .raddr (oldest),
        .rdata (ring_rdata)
    );

    // Running sum divided by the fill count
    fsfs_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_next),
        .den   (count_next),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_valid        = out_valid_reg;
    assign final_score      = o_final_reg;
    assign scene_part       = o_sp_reg;
    assign motion_part      = o_mp_reg;
    assign text_part        = o_tp_reg;
    assign frame_number_out = o_fn_reg;
    assign time_stamp_out   = o_ts_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(WINDOW_MAX))
        else $error("history count exceeds ring depth");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("running sum not zero with empty history");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result shown outside the output step");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PS))
        else $error("accepted beat did not start the sequence");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");
`endif

endmodule

@@ rtl/fsfs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
module fsfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fsfs_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on fsfs_pkg for the status struct.
module fsfs_div
    import fsfs_pkg::*;
#(
    parameter int NUM_W = 21,
    parameter int DEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

@@ tb/frame_score_fuse_smooth_test.sv @@
// Self-checking testbench for frame_score_fuse_smooth: weighted fusion, boosts, EMA and SMA.
// A directed stimulus table then randomised register phases, checked against a local predictor.
// Depends on fsfs_pkg and the RTL top level only.
`timescale 1ns / 1ps

module frame_score_fuse_smooth_test;
    import fsfs_pkg::*;

    localparam int RING_DEPTH       = 32;
    localparam int RANDOM_PHASES    = 12;
    localparam int FRAMES_PER_PHASE = 50;
    localparam int QUIET_LIMIT      = 1000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [15:0] scene_score;
        logic [15:0] motion_score;
        logic [15:0] text_score;
        logic        scene_change;
        logic [15:0] motion_level;
        logic [15:0] text_change_ratio;
        logic [30:0] frame_number;
        logic [62:0] time_stamp;
        logic        restart;
    } frame_t;

    typedef struct packed {
        logic [15:0] final_score;
        logic [15:0] scene_part;
        logic [15:0] motion_part;
        logic [15:0] text_part;
        logic [30:0] frame_number;
        logic [62:0] time_stamp;
    } score_t;

    typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_index;
        logic [15:0] reg_data;
        frame_t      frame;
        logic        known;
        score_t      known_score;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    frame_t      in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] final_score, scene_part, motion_part, text_part;
    logic [30:0] frame_number_out;
    logic [62:0] time_stamp_out;

    // Predictor copy of the registers and the smoothing history
    logic [15:0] w_scene, w_motion, w_text;
    logic [15:0] b_scene, b_motion, b_text;
    logic [15:0] alpha_q15;
    logic [5:0]  window_len;
    logic        ema_started;
    logic [15:0] ema_level;
    logic [15:0] hist [RING_DEPTH];
    logic [4:0]  hist_wr;
    logic [5:0]  hist_fill;
    logic [20:0] hist_sum;

    score_t    pending_scores [$];
    stim_row_t directed_rows [$];

    logic idle_on = 1'b1;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   results_checked = 0;
    int   frames_sent = 0;
    int   reg_writes = 0;
    int   restarts = 0;
    int   ema_frames = 0;
    int   sma_frames = 0;
    int   pass_frames = 0;

    frame_score_fuse_smooth #(
        .WINDOW_MAX(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .scene_score(in_beat.scene_score),
        .motion_score(in_beat.motion_score),
        .text_score(in_beat.text_score),
        .scene_change(in_beat.scene_change),
        .motion_level(in_beat.motion_level),
        .text_change_ratio(in_beat.text_change_ratio),
        .frame_number(in_beat.frame_number),
        .time_stamp(in_beat.time_stamp),
        .restart(in_beat.restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .final_score(final_score),
        .scene_part(scene_part),
        .motion_part(motion_part),
        .text_part(text_part),
        .frame_number_out(frame_number_out),
        .time_stamp_out(time_stamp_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_history();
        ema_started = 1'b0;
        ema_level   = '0;
        hist_wr     = '0;
        hist_fill   = '0;
        hist_sum    = '0;
    endfunction

    function automatic logic [15:0] cap_q15(input logic [19:0] x);
        return (x > 20'(ONE_Q15)) ? ONE_Q15 : x[15:0];
    endfunction

    // Round score*weight to nearest in Q1.15, unclamped
    function automatic logic [17:0] weigh(input logic [15:0] score, input logic [15:0] weight);
        logic [32:0] prod;
        prod = 33'(score) * 33'(weight) + ROUND15;
        return prod[32:15];
    endfunction

    function automatic logic [15:0] apply_boost(input logic [15:0] v, input logic [15:0] factor,
                                                input logic trig);
        logic [32:0] prod;
        if (factor <= ONE_Q12 || !trig)
            return v;
        prod = (33'(v) * 33'(factor) + ROUND12) >> 12;
        return cap_q15(prod[19:0]);
    endfunction

    function automatic logic [15:0] smooth_level(input logic [15:0] v);
        logic [5:0]  span;
        logic [4:0]  oldest;
        logic [32:0] blend;
        // EMA when alpha is valid; frames taken this way stay out of the ring
        if (alpha_q15 >= 16'd1 && alpha_q15 <= ONE_Q15)
        begin
            if (!ema_started && hist_fill == 6'd0)
                ema_level = v;
            else
            begin
                blend = 33'(alpha_q15) * 33'(v) + 33'(ONE_Q15 - alpha_q15) * 33'(ema_level)
                        + ROUND15;
                ema_level = blend[30:15];
            end
            ema_started = 1'b1;
            ema_frames++;
            return ema_level;
        end
        span = (window_len > 6'(RING_DEPTH)) ? 6'(RING_DEPTH) : window_len;
        if (span <= 6'd1)
        begin
            pass_frames++;
            return v;
        end
        // Drop at most one old value per frame, so a shrunk window catches up slowly
        if (hist_fill >= span)
        begin
            oldest    = hist_wr - hist_fill[4:0];
            hist_sum  = hist_sum - 21'(hist[oldest]);
            hist_fill = hist_fill - 6'd1;
        end
        hist[hist_wr] = v;
        hist_wr   = hist_wr + 5'd1;
        hist_sum  = hist_sum + 21'(v);
        hist_fill = hist_fill + 6'd1;
        sma_frames++;
        return 16'(hist_sum / 21'(hist_fill));
    endfunction

    function automatic score_t fuse_and_smooth(input frame_t f);
        score_t      r;
        logic [17:0] ps, pm, pt;
        logic [15:0] v;
        if (f.restart)
            clear_history();
        ps = weigh(f.scene_score, w_scene);
        pm = weigh(f.motion_score, w_motion);
        pt = weigh(f.text_score, w_text);
        v = cap_q15(20'(ps) + 20'(pm) + 20'(pt));
        // Boosts chain in the order scene, motion, text
        v = apply_boost(v, b_scene, f.scene_change);
        v = apply_boost(v, b_motion, f.motion_level > MOTION_THRESH);
        v = apply_boost(v, b_text, f.text_change_ratio > TEXT_THRESH);
        r.final_score  = smooth_level(v);
        r.scene_part   = cap_q15(20'(ps));
        r.motion_part  = cap_q15(20'(pm));
        r.text_part    = cap_q15(20'(pt));
        r.frame_number = f.frame_number;
        r.time_stamp   = f.time_stamp;
        return r;
    endfunction

    // Register values after reset
    function automatic void load_defaults();
        w_scene    = 16'd14746;
        w_motion   = 16'd6554;
        w_text     = 16'd11469;
        b_scene    = ONE_Q12;
        b_motion   = ONE_Q12;
        b_text     = ONE_Q12;
        alpha_q15  = '0;
        window_len = '0;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_WEIGHT_SCENE:  w_scene    = data;
            CFG_WEIGHT_MOTION: w_motion   = data;
            CFG_WEIGHT_TEXT:   w_text     = data;
            CFG_SCENE_BOOST:   b_scene    = data;
            CFG_MOTION_BOOST:  b_motion   = data;
            CFG_TEXT_BOOST:    b_text     = data;
            CFG_EMA_ALPHA:     alpha_q15  = data;
            CFG_SMOOTH_WINDOW: window_len = data[5:0];
            default:           ;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe drain
    task automatic settle(input int drain_cycles);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (drain_cycles) @(posedge clk);
    endtask

    task automatic drive_frame(input frame_t f, input logic known, input score_t known_score);
        score_t want;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= f;
        do
            @(posedge clk);
        while (in_stall);
        // Beat taken at this edge: hold the predictor in step with the block
        want = fuse_and_smooth(f);
        if (known)
        begin
            want.final_score = known_score.final_score;
            want.scene_part  = known_score.scene_part;
            want.motion_part = known_score.motion_part;
            want.text_part   = known_score.text_part;
        end
        pending_scores = {pending_scores, want};
        frames_sent++;
        if (f.restart)
            restarts++;
    endtask

    // ---------------------------------------------------------------- stimulus table

    task automatic add_write(input logic [2:0] idx, input logic [15:0] data);
        stim_row_t row;
        row = '{kind: ROW_WRITE, reg_index: idx, reg_data: data, default: '0};
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_frame(input int s, input int m, input int t, input bit sc, input int ml,
                             input int tr, input bit rs, input bit wide_ids, input bit known,
                             input int kf, input int ks, input int km, input int kt);
        stim_row_t row;
        row = '{kind: ROW_FRAME, default: '0};
        row.frame.scene_score       = 16'(s);
        row.frame.motion_score      = 16'(m);
        row.frame.text_score        = 16'(t);
        row.frame.scene_change      = sc;
        row.frame.motion_level      = 16'(ml);
        row.frame.text_change_ratio = 16'(tr);
        row.frame.restart           = rs;
        row.frame.frame_number      = wide_ids ? '1 : 31'($urandom);
        row.frame.time_stamp        = wide_ids ? '1 : 63'({$urandom, $urandom});
        row.known                   = known;
        row.known_score.final_score = 16'(kf);
        row.known_score.scene_part  = 16'(ks);
        row.known_score.motion_part = 16'(km);
        row.known_score.text_part   = 16'(kt);
        directed_rows = {directed_rows, row};
    endtask

    task automatic build_directed();
        // Reset weights: zero frame, one over 1.0 in sum, out-of-range scores
        add_frame(0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0);
        add_frame(32768, 32768, 32768, 0, 0, 0, 0, 0, 1, 32768, 14746, 6554, 11469);
        add_frame(65535, 65535, 65535, 1, 65535, 65535, 0, 1, 1, 32768, 29492, 13108, 22938);
        // Saturate the part outputs
        add_write(CFG_WEIGHT_SCENE, 16'd65535);
        add_write(CFG_WEIGHT_MOTION, 16'd0);
        add_write(CFG_WEIGHT_TEXT, 16'd32768);
        add_frame(65535, 65535, 65535, 0, 0, 0, 0, 0, 1, 32768, 32768, 0, 32768);
        // Boost triggers just at and just over their thresholds
        add_write(CFG_WEIGHT_SCENE, 16'd16384);
        add_write(CFG_WEIGHT_MOTION, 16'd8192);
        add_write(CFG_WEIGHT_TEXT, 16'd8192);
        add_write(CFG_SCENE_BOOST, 16'd8192);
        add_write(CFG_MOTION_BOOST, 16'd6144);
        add_write(CFG_TEXT_BOOST, 16'd65535);
        add_frame(8192, 0, 0, 1, 16384, 3276, 0, 0, 1, 8192, 4096, 0, 0);
        add_frame(8192, 0, 0, 0, 16385, 3276, 0, 0, 1, 6144, 4096, 0, 0);
        add_frame(8192, 0, 0, 0, 0, 3277, 0, 0, 1, 32768, 4096, 0, 0);
        add_frame(4000, 3000, 2000, 1, 20000, 4000, 0, 0, 0, 0, 0, 0, 0);
        // Factors of exactly 1.0 and of zero are not applied
        add_write(CFG_SCENE_BOOST, ONE_Q12);
        add_write(CFG_MOTION_BOOST, 16'd0);
        add_frame(8192, 0, 0, 1, 32768, 0, 0, 0, 1, 4096, 4096, 0, 0);
        // EMA: first value after restart, then blending
        add_write(CFG_EMA_ALPHA, 16'd16384);
        add_frame(16384, 0, 0, 0, 0, 0, 1, 0, 1, 8192, 8192, 0, 0);
        add_frame(0, 0, 0, 0, 0, 0, 0, 0, 1, 4096, 0, 0, 0);
        add_frame(32768, 32768, 32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(4096, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_write(CFG_EMA_ALPHA, ONE_Q15);
        add_frame(20000, 10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_write(CFG_EMA_ALPHA, 16'd1);
        add_frame(32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Alpha over 1.0 is invalid, so the moving average takes over
        add_write(CFG_EMA_ALPHA, 16'd40000);
        add_write(CFG_SMOOTH_WINDOW, 16'd4);
        add_frame(30000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(32768, 32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(20000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        // Window over the ring size, then shrunk
        add_write(CFG_SMOOTH_WINDOW, 16'd63);
        add_frame(12345, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_write(CFG_SMOOTH_WINDOW, 16'd2);
        add_frame(3000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_frame(9000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_write(CFG_SMOOTH_WINDOW, 16'd1);
        add_frame(5000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // EMA with a non-empty ring: not a first value
        add_write(CFG_EMA_ALPHA, 16'd16384);
        add_frame(24000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // ---------------------------------------------------------------- random picks

    function automatic logic [15:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q15;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_level(input logic [15:0] thresh);
        case ($urandom_range(0, 7))
            0:       return thresh;
            1:       return thresh + 16'd1;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.scene_score       = pick_score();
        f.motion_score      = pick_score();
        f.text_score        = pick_score();
        f.scene_change      = 1'($urandom_range(0, 1));
        f.motion_level      = pick_level(MOTION_THRESH);
        f.text_change_ratio = pick_level(TEXT_THRESH);
        f.frame_number      = 31'($urandom);
        f.time_stamp        = 63'({$urandom, $urandom});
        f.restart           = ($urandom_range(0, 24) == 0);
        return f;
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_Q15;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_boost();
        case ($urandom_range(0, 5))
            0:       return ONE_Q12;
            1:       return 16'($urandom_range(0, 4096));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(4097, 12288));
        endcase
    endfunction

    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4:          return 16'd1;
            5:          return ONE_Q15;
            6:          return 16'($urandom_range(32769, 65535));
            default:    return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(0, 1));
            1:       return 16'(RING_DEPTH);
            2:       return 16'($urandom_range(33, 63));
            3:       return 16'($urandom_range(9, 31));
            default: return 16'($urandom_range(2, 8));
        endcase
    endfunction

    // First phases pin the extremes, the rest are random
    task automatic program_phase(input int phase);
        logic [15:0] v [8];
        case (phase)
            0:
            begin
                v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            end
            1:
            begin
                v = '{ONE_Q15, ONE_Q15, ONE_Q15, 16'hFFFF, 16'hFFFF, 16'hFFFF, ONE_Q15,
                      16'(RING_DEPTH)};
            end
            2:
            begin
                v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, ONE_Q12, 16'd4097, ONE_Q12, 16'hFFFF,
                      16'd63};
            end
            default:
            begin
                v = '{pick_weight(), pick_weight(), pick_weight(), pick_boost(), pick_boost(),
                      pick_boost(), pick_alpha(), pick_window()};
            end
        endcase
        write_reg(CFG_WEIGHT_SCENE, v[0]);
        write_reg(CFG_WEIGHT_MOTION, v[1]);
        write_reg(CFG_WEIGHT_TEXT, v[2]);
        write_reg(CFG_SCENE_BOOST, v[3]);
        write_reg(CFG_MOTION_BOOST, v[4]);
        write_reg(CFG_TEXT_BOOST, v[5]);
        write_reg(CFG_EMA_ALPHA, v[6]);
        write_reg(CFG_SMOOTH_WINDOW, v[7]);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin : stimulus
        stim_row_t row;
        load_defaults();
        clear_history();
        build_directed();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register writes only once the block is idle
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                settle(4);
                write_reg(row.reg_index, row.reg_data);
            end
            else
                drive_frame(row.frame, row.known, row.known_score);
        end

        // Random frames under a fresh register setting per phase; last phase runs flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle(4);
            program_phase(phase);
            idle_on = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (FRAMES_PER_PHASE) drive_frame(random_frame(), 1'b0, '0);
        end

        settle(40);
        $display("Covered %0d frames, %0d restarts and %0d register writes; %0d results checked",
                 frames_sent, restarts, reg_writes, results_checked);
        $display("Smoothing paths: %0d EMA, %0d moving average, %0d passthrough",
                 ema_frames, sma_frames, pass_frames);
        if (mismatches == 0 && pending_scores.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    always @(posedge clk)
    begin : result_sink
        score_t got;
        score_t want;
        // Stall in random bursts
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;

        if (rst_n)
        begin
            // Compare each accepted beat with the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = '{final_score, scene_part, motion_part, text_part, frame_number_out,
                        time_stamp_out};
                results_checked++;
                if (pending_scores.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: frame %0d score %0d",
                                 got.frame_number, got.final_score);
                end
                else
                begin
                    want = pending_scores.pop_front();
                    if (got.final_score !== want.final_score
                        || got.scene_part !== want.scene_part
                        || got.motion_part !== want.motion_part
                        || got.text_part !== want.text_part
                        || got.frame_number !== want.frame_number
                        || got.time_stamp !== want.time_stamp)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected score %0d parts %0d/%0d/%0d frame %0d ts %0d",
                                     $realtime, want.final_score, want.scene_part,
                                     want.motion_part, want.text_part, want.frame_number,
                                     want.time_stamp);
                            $display("%0t:   actual score %0d parts %0d/%0d/%0d frame %0d ts %0d",
                                     $realtime, got.final_score, got.scene_part,
                                     got.motion_part, got.text_part, got.frame_number,
                                     got.time_stamp);
                        end
                    end
                end
            end

            // Watchdog: end the run if no beat moves on either side for too long
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_scores.size());
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
rtl/fsfs_pkg.sv
rtl/fsfs_ram.sv
rtl/fsfs_div.sv
rtl/frame_score_fuse_smooth.sv
tb/frame_score_fuse_smooth_test.sv
